>>> rtl/scms_pkg.sv
// Package for the servo chute move sequencer.
// Holds the opcode, mode, fail and register codes and the shared structs.
// No dependencies.
package scms_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SORT  = 2'd1,
        OP_STOW  = 2'd2,
        OP_ESTOP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_STOWED  = 2'd0,
        MODE_MOVING  = 2'd1,
        MODE_AT_BIN  = 2'd2,
        MODE_STOWING = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        FAIL_NONE       = 3'd0,
        FAIL_BUSY       = 3'd1,
        FAIL_ARM        = 3'd2,
        FAIL_GRIPPER    = 3'd3,
        FAIL_ARM_SW     = 3'd4,
        FAIL_GRIPPER_SW = 3'd5,
        FAIL_WHEELS     = 3'd6,
        FAIL_ESTOP      = 3'd7
    } t_fail;

    typedef enum logic [2:0] {
        REG_ANGLE_STOW   = 3'd0,
        REG_ANGLE_SMALL  = 3'd1,
        REG_ANGLE_MEDIUM = 3'd2,
        REG_ANGLE_LARGE  = 3'd3,
        REG_STEP_DEG     = 3'd4,
        REG_STEP_DELAY   = 3'd5,
        REG_MOVE_TIMEOUT = 3'd6,
        REG_BIN_PAUSE    = 3'd7
    } t_reg_idx;

    localparam logic [1:0] BIN_SMALL  = 2'd0;
    localparam logic [1:0] BIN_MEDIUM = 2'd1;

    localparam logic [7:0]  RST_ANGLE_STOW   = 8'd0;
    localparam logic [7:0]  RST_ANGLE_SMALL  = 8'd45;
    localparam logic [7:0]  RST_ANGLE_MEDIUM = 8'd90;
    localparam logic [7:0]  RST_ANGLE_LARGE  = 8'd135;
    localparam logic [7:0]  RST_STEP_DEG     = 8'd2;
    localparam logic [15:0] RST_STEP_DELAY   = 16'd15;
    localparam logic [15:0] RST_MOVE_TIMEOUT = 16'd3000;
    localparam logic [15:0] RST_BIN_PAUSE    = 16'd200;

    typedef struct packed {
        logic [7:0]  angle_stow;
        logic [7:0]  angle_small;
        logic [7:0]  angle_medium;
        logic [7:0]  angle_large;
        logic [7:0]  step_degrees;
        logic [15:0] step_delay_ticks;
        logic [15:0] move_timeout_ticks;
        logic [15:0] bin_pause_ticks;
    } t_cfg;

    typedef struct packed {
        t_op        opcode;
        logic [1:0] bin_select;
        logic       arm_at_home;
        logic       gripper_closed;
        logic       arm_switch_ok;
        logic       gripper_switch_ok;
        logic       wheels_stopped;
        logic       estop_active;
    } t_item;

    typedef struct packed {
        logic       accepted;
        t_fail      fail_code;
        t_mode      machine_state;
        logic [7:0] servo_angle;
        logic       busy_res;
    } t_result;

endpackage

>>> rtl/scms_cfg.sv
// APB register file for the servo chute move sequencer.
// Eight registers at byte addresses 4*i; depends on scms_pkg.
module scms_cfg
    import scms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_stow         <= RST_ANGLE_STOW;
            r_cfg.angle_small        <= RST_ANGLE_SMALL;
            r_cfg.angle_medium       <= RST_ANGLE_MEDIUM;
            r_cfg.angle_large        <= RST_ANGLE_LARGE;
            r_cfg.step_degrees       <= RST_STEP_DEG;
            r_cfg.step_delay_ticks   <= RST_STEP_DELAY;
            r_cfg.move_timeout_ticks <= RST_MOVE_TIMEOUT;
            r_cfg.bin_pause_ticks    <= RST_BIN_PAUSE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ANGLE_STOW:   r_cfg.angle_stow         <= pwdata[7:0];
                REG_ANGLE_SMALL:  r_cfg.angle_small        <= pwdata[7:0];
                REG_ANGLE_MEDIUM: r_cfg.angle_medium       <= pwdata[7:0];
                REG_ANGLE_LARGE:  r_cfg.angle_large        <= pwdata[7:0];
                REG_STEP_DEG:     r_cfg.step_degrees       <= pwdata[7:0];
                REG_STEP_DELAY:   r_cfg.step_delay_ticks   <= pwdata[15:0];
                REG_MOVE_TIMEOUT: r_cfg.move_timeout_ticks <= pwdata[15:0];
                REG_BIN_PAUSE:    r_cfg.bin_pause_ticks    <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ANGLE_STOW:   prdata = {24'd0, r_cfg.angle_stow};
            REG_ANGLE_SMALL:  prdata = {24'd0, r_cfg.angle_small};
            REG_ANGLE_MEDIUM: prdata = {24'd0, r_cfg.angle_medium};
            REG_ANGLE_LARGE:  prdata = {24'd0, r_cfg.angle_large};
            REG_STEP_DEG:     prdata = {24'd0, r_cfg.step_degrees};
            REG_STEP_DELAY:   prdata = {16'd0, r_cfg.step_delay_ticks};
            REG_MOVE_TIMEOUT: prdata = {16'd0, r_cfg.move_timeout_ticks};
            REG_BIN_PAUSE:    prdata = {16'd0, r_cfg.bin_pause_ticks};
        endcase
    end

endmodule

>>> rtl/scms_core.sv
// Sequencer state and per-beat next-state logic for the servo chute.
// Holds mode, angles and the saturating tick counters; depends on scms_pkg.
module scms_core
    import scms_pkg::*;
#(
    parameter int TIMER_BITS = 16,
    parameter int ANGLE_MAX  = 180
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    // compare width wide enough for the move counter and the 16-bit registers
    localparam int CW = (TIMER_BITS + 1 > 17) ? TIMER_BITS + 1 : 17;

    function automatic logic [7:0] clamp_angle(input logic [7:0] a);
        clamp_angle = (32'(a) > ANGLE_MAX) ? 8'(ANGLE_MAX) : a;
    endfunction

    t_mode                 r_mode,  n_mode;
    logic [7:0]            r_cur,   n_cur;
    logic [7:0]            r_tgt,   n_tgt;
    logic [TIMER_BITS-1:0] r_tss,   n_tss;
    logic [TIMER_BITS:0]   r_tim,   n_tim;
    logic [TIMER_BITS-1:0] r_tsa,   n_tsa;

    logic [TIMER_BITS-1:0] w_tss_inc, w_tsa_inc;
    logic [TIMER_BITS:0]   w_tim_inc;
    logic                  w_busy, w_up;
    logic [7:0]            w_dist, w_bin_angle;
    t_fail                 w_lock_fail;

    assign w_busy    = (r_mode == MODE_MOVING) || (r_mode == MODE_STOWING);
    assign w_tss_inc = (&r_tss) ? r_tss : r_tss + 1'b1;
    assign w_tim_inc = (&r_tim) ? r_tim : r_tim + 1'b1;
    assign w_tsa_inc = (&r_tsa) ? r_tsa : r_tsa + 1'b1;
    assign w_up      = r_tgt > r_cur;
    assign w_dist    = w_up ? r_tgt - r_cur : r_cur - r_tgt;

    always_comb begin
        unique case (i_item.bin_select)
            BIN_SMALL:  w_bin_angle = i_cfg.angle_small;
            BIN_MEDIUM: w_bin_angle = i_cfg.angle_medium;
            default:    w_bin_angle = i_cfg.angle_large;
        endcase
    end

    always_comb begin
        priority if (!i_item.arm_at_home)       w_lock_fail = FAIL_ARM;
        else if (!i_item.gripper_closed)        w_lock_fail = FAIL_GRIPPER;
        else if (!i_item.arm_switch_ok)         w_lock_fail = FAIL_ARM_SW;
        else if (!i_item.gripper_switch_ok)     w_lock_fail = FAIL_GRIPPER_SW;
        else if (!i_item.wheels_stopped)        w_lock_fail = FAIL_WHEELS;
        else if (i_item.estop_active)           w_lock_fail = FAIL_ESTOP;
        else                                    w_lock_fail = FAIL_NONE;
    end

    always_comb begin
        n_mode = r_mode;
        n_cur  = r_cur;
        n_tgt  = r_tgt;
        n_tss  = r_tss;
        n_tim  = r_tim;
        n_tsa  = r_tsa;
        o_res.accepted  = 1'b0;
        o_res.fail_code = FAIL_NONE;

        unique case (i_item.opcode)
            OP_TICK: begin
                // counters advance first, then the machine looks at them
                n_tss = w_tss_inc;
                n_tim = w_tim_inc;
                n_tsa = w_tsa_inc;
                if (w_busy) begin
                    if (CW'(w_tim_inc) > CW'(i_cfg.move_timeout_ticks)) begin
                        n_mode = (r_mode == MODE_MOVING) ? MODE_AT_BIN : MODE_STOWED;
                    end else if (CW'(w_tss_inc) >= CW'(i_cfg.step_delay_ticks)) begin
                        n_tss = '0;
                        if (r_cur == r_tgt) begin
                            if (r_mode == MODE_MOVING) begin
                                n_mode = MODE_AT_BIN;
                                n_tsa  = '0;
                            end else begin
                                n_mode = MODE_STOWED;
                            end
                        end else if (i_cfg.step_degrees >= w_dist) begin
                            n_cur = r_tgt;
                        end else begin
                            n_cur = w_up ? r_cur + i_cfg.step_degrees
                                         : r_cur - i_cfg.step_degrees;
                        end
                    end
                end else if (r_mode == MODE_AT_BIN) begin
                    if (CW'(w_tsa_inc) >= CW'(i_cfg.bin_pause_ticks)) begin
                        n_tgt  = clamp_angle(i_cfg.angle_stow);
                        n_tim  = '0;
                        n_mode = MODE_STOWING;
                    end
                end
            end
            OP_SORT: begin
                if (w_busy) begin
                    o_res.fail_code = FAIL_BUSY;
                end else begin
                    o_res.fail_code = w_lock_fail;
                    if (w_lock_fail == FAIL_NONE) begin
                        n_tgt  = clamp_angle(w_bin_angle);
                        n_tim  = '0;
                        n_mode = MODE_MOVING;
                        o_res.accepted = 1'b1;
                    end
                end
            end
            OP_STOW: begin
                if (w_busy) begin
                    o_res.fail_code = FAIL_BUSY;
                end else begin
                    n_tgt  = clamp_angle(i_cfg.angle_stow);
                    n_tim  = '0;
                    n_mode = MODE_STOWING;
                    o_res.accepted = 1'b1;
                end
            end
            OP_ESTOP: begin
                // freeze where we are
                n_tgt  = r_cur;
                n_mode = MODE_STOWED;
            end
        endcase

        o_res.machine_state = n_mode;
        o_res.servo_angle   = n_cur;
        o_res.busy_res      = (n_mode != MODE_STOWED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_STOWED;
            r_cur  <= clamp_angle(RST_ANGLE_STOW);
            r_tgt  <= clamp_angle(RST_ANGLE_STOW);
            r_tss  <= '0;
            r_tim  <= '0;
            r_tsa  <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_cur  <= n_cur;
            r_tgt  <= n_tgt;
            r_tss  <= n_tss;
            r_tim  <= n_tim;
            r_tsa  <= n_tsa;
        end
    end

endmodule

>>> rtl/servo_chute_move_sequencer.sv
// Servo chute move sequencer, top level.
// An accepted item is held in the input register, then passes through the
// sequencer logic into the result register, where the receiver takes it.
// Throughput: one item per cycle unless the output stalls.
// Reset (synchronous, active low) returns registers to their defaults,
// the machine to stowed at angle 0, clears the counters and both stages.
module servo_chute_move_sequencer
    import scms_pkg::*;
#(
    parameter int TIMER_BITS = 16,
    parameter int ANGLE_MAX  = 180
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [1:0]  i_bin_select,
    input  logic        i_arm_at_home,
    input  logic        i_gripper_closed,
    input  logic        i_arm_switch_ok,
    input  logic        i_gripper_switch_ok,
    input  logic        i_wheels_stopped,
    input  logic        i_estop_active,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_accepted,
    output logic [2:0]  o_fail_code,
    output logic [1:0]  o_machine_state,
    output logic [7:0]  o_servo_angle,
    output logic        o_busy_res
);

    t_cfg    w_cfg;
    t_item   r_item;
    logic    r_in_vld;
    logic    r_out_vld, n_out_vld;
    t_result r_res, w_res;
    logic    w_adv, w_take;

    scms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // item moves into the sequencer when the result register is free or draining
    assign w_adv      = r_in_vld & (~r_out_vld | ~i_out_stall);
    assign o_in_stall = r_in_vld & ~w_adv;
    assign w_take     = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (~r_in_vld | w_adv) begin
            r_in_vld <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.opcode            <= t_op'(i_opcode);
            r_item.bin_select        <= i_bin_select;
            r_item.arm_at_home       <= i_arm_at_home;
            r_item.gripper_closed    <= i_gripper_closed;
            r_item.arm_switch_ok     <= i_arm_switch_ok;
            r_item.gripper_switch_ok <= i_gripper_switch_ok;
            r_item.wheels_stopped    <= i_wheels_stopped;
            r_item.estop_active      <= i_estop_active;
        end
    end

    scms_core #(
        .TIMER_BITS (TIMER_BITS),
        .ANGLE_MAX  (ANGLE_MAX)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_comb begin
        if (w_adv) begin
            n_out_vld = 1'b1;
        end else begin
            n_out_vld = r_out_vld & i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_accepted      = r_res.accepted;
    assign o_fail_code     = r_res.fail_code;
    assign o_machine_state = r_res.machine_state;
    assign o_servo_angle   = r_res.servo_angle;
    assign o_busy_res      = r_res.busy_res;

endmodule

>>> rtl/scms_chk.sv
// Port-level checks for the servo chute move sequencer, bound to the top.
// Depends on scms_pkg and servo_chute_move_sequencer.
module scms_chk
    import scms_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_accepted,
    input logic [2:0] o_fail_code,
    input logic [1:0] o_machine_state,
    input logic [7:0] o_servo_angle,
    input logic       o_busy_res
);

    // busy flag must agree with the reported state
    a_busy_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_busy_res == (o_machine_state != MODE_STOWED)))
        else $error("busy_res disagrees with machine_state");

    // an accepted command carries no failure and leaves the machine moving or stowing
    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |->
            (o_fail_code == FAIL_NONE) &&
            (o_machine_state == MODE_MOVING || o_machine_state == MODE_STOWING))
        else $error("accepted beat with failure code or idle state");

    // no result beat is offered in the cycle after a reset edge
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_servo_angle) && $stable(o_machine_state)))
        else $error("stalled result beat changed");

endmodule

bind servo_chute_move_sequencer scms_chk u_scms_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_accepted      (o_accepted),
    .o_fail_code     (o_fail_code),
    .o_machine_state (o_machine_state),
    .o_servo_angle   (o_servo_angle),
    .o_busy_res      (o_busy_res)
);

>>> tb/tb_servo_chute_move_sequencer.sv
// Self-checking testbench for the servo chute move sequencer.
// Holds its own model of the sequencer, stimulus, APB set-up and result checker.
// Depends on rtl/scms_pkg.sv and rtl/servo_chute_move_sequencer.sv.
module tb_servo_chute_move_sequencer;
    timeunit 1ns;
    timeprecision 1ps;
    import scms_pkg::*;

    localparam int         ANGLE_LIMIT = 180;
    localparam int         HOLD_CYCLES = 80;
    localparam logic [1:0] BIN_LARGE   = 2'd2;
    localparam logic [1:0] BIN_BEYOND  = 2'd3;
    // interlock bits in item order: arm, gripper, arm sw, gripper sw, wheels, estop
    localparam logic [5:0] LOCKS_OK    = 6'b111110;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_opcode = '0;
    logic [1:0]  i_bin_select = '0;
    logic        i_arm_at_home = 1'b0;
    logic        i_gripper_closed = 1'b0;
    logic        i_arm_switch_ok = 1'b0;
    logic        i_gripper_switch_ok = 1'b0;
    logic        i_wheels_stopped = 1'b0;
    logic        i_estop_active = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_accepted;
    logic [2:0]  o_fail_code;
    logic [1:0]  o_machine_state;
    logic [7:0]  o_servo_angle;
    logic        o_busy_res;

    servo_chute_move_sequencer uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_bin_select       (i_bin_select),
        .i_arm_at_home      (i_arm_at_home),
        .i_gripper_closed   (i_gripper_closed),
        .i_arm_switch_ok    (i_arm_switch_ok),
        .i_gripper_switch_ok(i_gripper_switch_ok),
        .i_wheels_stopped   (i_wheels_stopped),
        .i_estop_active     (i_estop_active),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_accepted         (o_accepted),
        .o_fail_code        (o_fail_code),
        .o_machine_state    (o_machine_state),
        .o_servo_angle      (o_servo_angle),
        .o_busy_res         (o_busy_res)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // sequencer model state and register copies
    logic [15:0] reg_shadow [8];
    t_mode       seq_mode;
    logic [7:0]  servo_deg;
    logic [7:0]  target_deg;
    logic [15:0] since_step;
    logic [16:0] in_move;
    logic [15:0] since_arrival;

    t_result     awaited_results [$];
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_on = 1'b0;
    int          beats_sent = 0;
    int          results_checked = 0;
    int          mismatches = 0;
    int          sorts_taken = 0;
    int          refusals = 0;
    int          bin_arrivals = 0;
    int          move_timeouts = 0;

    function automatic logic [7:0] clamp_deg(logic [15:0] a);
        return (a > ANGLE_LIMIT) ? 8'(ANGLE_LIMIT) : a[7:0];
    endfunction

    function automatic t_result sequencer_step(t_item it);
        t_result r;
        logic    busy;
        int      cur;
        int      tgt;
        int      nxt;
        busy = (seq_mode == MODE_MOVING) || (seq_mode == MODE_STOWING);
        r.accepted  = 1'b0;
        r.fail_code = FAIL_NONE;
        case (it.opcode)
            OP_TICK: begin
                // counters move first, then the state machine looks at them
                if (since_step != 16'hffff) since_step++;
                if (in_move != 17'h1ffff) in_move++;
                if (since_arrival != 16'hffff) since_arrival++;
                if (busy) begin
                    if (in_move > reg_shadow[REG_MOVE_TIMEOUT]) begin
                        seq_mode = (seq_mode == MODE_MOVING) ? MODE_AT_BIN : MODE_STOWED;
                        move_timeouts++;
                    end else if (since_step >= reg_shadow[REG_STEP_DELAY]) begin
                        since_step = '0;
                        cur = servo_deg;
                        tgt = target_deg;
                        if (cur == tgt) begin
                            if (seq_mode == MODE_MOVING) begin
                                seq_mode = MODE_AT_BIN;
                                since_arrival = '0;
                                bin_arrivals++;
                            end else begin
                                seq_mode = MODE_STOWED;
                            end
                        end else if (tgt > cur) begin
                            nxt = cur + int'(reg_shadow[REG_STEP_DEG]);
                            servo_deg = (nxt > tgt) ? target_deg : 8'(nxt);
                        end else begin
                            nxt = cur - int'(reg_shadow[REG_STEP_DEG]);
                            servo_deg = (nxt < tgt) ? target_deg : 8'(nxt);
                        end
                    end
                end else if (seq_mode == MODE_AT_BIN &&
                             since_arrival >= reg_shadow[REG_BIN_PAUSE]) begin
                    target_deg = clamp_deg(reg_shadow[REG_ANGLE_STOW]);
                    in_move = '0;
                    seq_mode = MODE_STOWING;
                end
            end
            OP_SORT: begin
                if (busy) r.fail_code = FAIL_BUSY;
                else if (!it.arm_at_home) r.fail_code = FAIL_ARM;
                else if (!it.gripper_closed) r.fail_code = FAIL_GRIPPER;
                else if (!it.arm_switch_ok) r.fail_code = FAIL_ARM_SW;
                else if (!it.gripper_switch_ok) r.fail_code = FAIL_GRIPPER_SW;
                else if (!it.wheels_stopped) r.fail_code = FAIL_WHEELS;
                else if (it.estop_active) r.fail_code = FAIL_ESTOP;
                else begin
                    case (it.bin_select)
                        BIN_SMALL:  target_deg = clamp_deg(reg_shadow[REG_ANGLE_SMALL]);
                        BIN_MEDIUM: target_deg = clamp_deg(reg_shadow[REG_ANGLE_MEDIUM]);
                        default:    target_deg = clamp_deg(reg_shadow[REG_ANGLE_LARGE]);
                    endcase
                    in_move = '0;
                    seq_mode = MODE_MOVING;
                    r.accepted = 1'b1;
                    sorts_taken++;
                end
            end
            OP_STOW: begin
                // stow checks only for a move in progress, no interlocks
                if (busy) begin
                    r.fail_code = FAIL_BUSY;
                end else begin
                    target_deg = clamp_deg(reg_shadow[REG_ANGLE_STOW]);
                    in_move = '0;
                    seq_mode = MODE_STOWING;
                    r.accepted = 1'b1;
                end
            end
            OP_ESTOP: begin
                target_deg = servo_deg;
                seq_mode = MODE_STOWED;
            end
        endcase
        if (r.fail_code != FAIL_NONE) refusals++;
        r.machine_state = seq_mode;
        r.servo_angle   = servo_deg;
        r.busy_res      = (seq_mode != MODE_STOWED);
        return r;
    endfunction

    function automatic t_item make_item(t_op op, logic [1:0] bin, logic [5:0] locks);
        t_item it;
        it.opcode     = op;
        it.bin_select = bin;
        {it.arm_at_home, it.gripper_closed, it.arm_switch_ok,
         it.gripper_switch_ok, it.wheels_stopped, it.estop_active} = locks;
        return it;
    endfunction

    function automatic t_item random_item();
        int         roll;
        logic [5:0] locks;
        roll  = $urandom_range(99);
        locks = ($urandom_range(3) != 0) ? LOCKS_OK : 6'($urandom_range(63));
        if (roll < 55) return make_item(OP_TICK, 2'($urandom_range(3)), 6'($urandom_range(63)));
        if (roll < 80) return make_item(OP_SORT, 2'($urandom_range(3)), locks);
        if (roll < 93) return make_item(OP_STOW, 2'($urandom_range(3)), 6'($urandom_range(63)));
        return make_item(OP_ESTOP, 2'($urandom_range(3)), 6'($urandom_range(63)));
    endfunction

    function automatic logic [15:0] pick_angle();
        if ($urandom_range(9) == 0) return 16'($urandom_range(255, 181));
        return 16'($urandom_range(ANGLE_LIMIT));
    endfunction

    // called just after a rising edge; returns just after the edge that took the beat
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_opcode            <= it.opcode;
        i_bin_select        <= it.bin_select;
        i_arm_at_home       <= it.arm_at_home;
        i_gripper_closed    <= it.gripper_closed;
        i_arm_switch_ok     <= it.arm_switch_ok;
        i_gripper_switch_ok <= it.gripper_switch_ok;
        i_wheels_stopped    <= it.wheels_stopped;
        i_estop_active      <= it.estop_active;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        awaited_results.push_back(sequencer_step(it));
        beats_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(make_item(OP_TICK, 2'($urandom_range(3)), 6'($urandom_range(63))));
    endtask

    task automatic set_reg(input t_reg_idx idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_shadow[idx] = (idx <= REG_STEP_DEG) ? (value & 16'h00ff) : value;
        @(posedge i_clk);
    endtask

    // block idle: wait until no result is awaited, then let the pipeline settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_directed_sorts();
        wait_drained();
        set_reg(REG_STEP_DEG, 16'd60);
        set_reg(REG_STEP_DELAY, 16'd0);
        set_reg(REG_MOVE_TIMEOUT, 16'd20);
        set_reg(REG_BIN_PAUSE, 16'd1);
        // each interlock failing on its own, then several at once
        for (int b = 0; b < 6; b++) begin
            send_item(make_item(OP_SORT, BIN_SMALL, LOCKS_OK ^ (6'b100000 >> b)));
        end
        send_item(make_item(OP_SORT, BIN_SMALL, 6'b010001));
        send_item(make_item(OP_SORT, BIN_SMALL, LOCKS_OK));
        send_item(make_item(OP_SORT, BIN_MEDIUM, LOCKS_OK));
        send_item(make_item(OP_STOW, BIN_SMALL, LOCKS_OK));
        send_ticks(2);
        // sort again from the bin; bin select three behaves as large
        send_item(make_item(OP_SORT, BIN_BEYOND, LOCKS_OK));
        send_ticks(4);
        send_item(make_item(OP_ESTOP, BIN_BEYOND, 6'b111111));
        send_item(make_item(OP_STOW, BIN_BEYOND, 6'b000000));
        send_ticks(3);
        send_item(make_item(OP_SORT, BIN_MEDIUM, LOCKS_OK));
        send_ticks(2);
    endtask

    task automatic test_config_extremes();
        // angles beyond the servo range, biggest step, no step delay, no dwell
        wait_drained();
        set_reg(REG_ANGLE_STOW, 16'd255);
        set_reg(REG_ANGLE_SMALL, 16'd0);
        set_reg(REG_ANGLE_MEDIUM, 16'd180);
        set_reg(REG_ANGLE_LARGE, 16'd200);
        set_reg(REG_STEP_DEG, 16'd180);
        set_reg(REG_STEP_DELAY, 16'd0);
        set_reg(REG_MOVE_TIMEOUT, 16'd65534);
        set_reg(REG_BIN_PAUSE, 16'd0);
        send_item(make_item(OP_ESTOP, BIN_SMALL, LOCKS_OK));
        send_item(make_item(OP_STOW, BIN_SMALL, LOCKS_OK));
        send_ticks(3);
        send_item(make_item(OP_SORT, BIN_BEYOND, LOCKS_OK));
        send_ticks(4);
        send_item(make_item(OP_SORT, BIN_SMALL, LOCKS_OK));
        send_ticks(4);

        // zero step: the angle stays put and only the timeout ends the move
        wait_drained();
        set_reg(REG_STEP_DEG, 16'd0);
        set_reg(REG_MOVE_TIMEOUT, 16'd5);
        send_item(make_item(OP_ESTOP, BIN_SMALL, LOCKS_OK));
        send_item(make_item(OP_SORT, BIN_MEDIUM, LOCKS_OK));
        send_ticks(8);

        // step delay at the counter's top value; longest dwell
        wait_drained();
        set_reg(REG_STEP_DEG, 16'd1);
        set_reg(REG_STEP_DELAY, 16'd65535);
        set_reg(REG_MOVE_TIMEOUT, 16'd3);
        set_reg(REG_BIN_PAUSE, 16'd65535);
        send_item(make_item(OP_ESTOP, BIN_SMALL, LOCKS_OK));
        send_item(make_item(OP_SORT, BIN_SMALL, LOCKS_OK));
        send_ticks(6);
        send_item(make_item(OP_SORT, BIN_LARGE, LOCKS_OK));
        send_ticks(6);
        send_item(make_item(OP_STOW, BIN_SMALL, LOCKS_OK));
        send_ticks(2);

        // zero timeout: any tick in a move ends it
        wait_drained();
        set_reg(REG_STEP_DELAY, 16'd0);
        set_reg(REG_MOVE_TIMEOUT, 16'd0);
        send_item(make_item(OP_ESTOP, BIN_SMALL, LOCKS_OK));
        send_item(make_item(OP_SORT, BIN_LARGE, LOCKS_OK));
        send_ticks(2);
        send_item(make_item(OP_STOW, BIN_SMALL, LOCKS_OK));
        send_ticks(2);
    endtask

    task automatic test_random_traffic(input int n_sets);
        for (int s = 0; s < n_sets; s++) begin
            wait_drained();
            set_reg(REG_ANGLE_STOW, pick_angle());
            set_reg(REG_ANGLE_SMALL, pick_angle());
            set_reg(REG_ANGLE_MEDIUM, pick_angle());
            set_reg(REG_ANGLE_LARGE, pick_angle());
            case ($urandom_range(9))
                0:       set_reg(REG_STEP_DEG, 16'd0);
                1:       set_reg(REG_STEP_DEG, 16'd180);
                default: set_reg(REG_STEP_DEG, 16'($urandom_range(90, 1)));
            endcase
            // mostly short delays and timeouts keep most moves within a few dozen ticks
            set_reg(REG_STEP_DELAY, ($urandom_range(19) == 0) ? 16'd65535 :
                                    16'($urandom_range(3)));
            case ($urandom_range(9))
                0:       set_reg(REG_MOVE_TIMEOUT, 16'd0);
                1:       set_reg(REG_MOVE_TIMEOUT, 16'd65534);
                default: set_reg(REG_MOVE_TIMEOUT, 16'($urandom_range(40, 4)));
            endcase
            set_reg(REG_BIN_PAUSE, ($urandom_range(19) == 0) ? 16'd65535 :
                                   16'($urandom_range(6)));
            repeat (110) send_item(random_item());
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        set_reg(REG_STEP_DEG, 16'd30);
        set_reg(REG_STEP_DELAY, 16'd1);
        set_reg(REG_MOVE_TIMEOUT, 16'd30);
        set_reg(REG_BIN_PAUSE, 16'd2);
        // receiver holds off while beats keep coming, so the input must stall
        hold_on <= 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on <= 1'b0;
            end
            repeat (40) send_item(random_item());
        join
    endtask

    always @(posedge i_clk) begin
        if (hold_on) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic log_mismatch(input string what, input t_result want, input t_result seen);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s) at %0t: expected acc=%0d fail=%0d state=%0d angle=%0d busy=%0d",
                     what, $realtime, want.accepted, want.fail_code, want.machine_state,
                     want.servo_angle, want.busy_res);
            $display("    got acc=%0d fail=%0d state=%0d angle=%0d busy=%0d",
                     seen.accepted, seen.fail_code, seen.machine_state,
                     seen.servo_angle, seen.busy_res);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result seen;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.accepted      = o_accepted;
            seen.fail_code     = t_fail'(o_fail_code);
            seen.machine_state = t_mode'(o_machine_state);
            seen.servo_angle   = o_servo_angle;
            seen.busy_res      = o_busy_res;
            results_checked++;
            if (awaited_results.size() == 0) begin
                want = '0;
                log_mismatch("nothing expected", want, seen);
            end else begin
                want = awaited_results.pop_front();
                if (seen.accepted !== want.accepted ||
                    seen.fail_code !== want.fail_code ||
                    seen.machine_state !== want.machine_state ||
                    seen.servo_angle !== want.servo_angle ||
                    seen.busy_res !== want.busy_res) begin
                    log_mismatch("field", want, seen);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        reg_shadow[REG_ANGLE_STOW]   = 16'(RST_ANGLE_STOW);
        reg_shadow[REG_ANGLE_SMALL]  = 16'(RST_ANGLE_SMALL);
        reg_shadow[REG_ANGLE_MEDIUM] = 16'(RST_ANGLE_MEDIUM);
        reg_shadow[REG_ANGLE_LARGE]  = 16'(RST_ANGLE_LARGE);
        reg_shadow[REG_STEP_DEG]     = 16'(RST_STEP_DEG);
        reg_shadow[REG_STEP_DELAY]   = RST_STEP_DELAY;
        reg_shadow[REG_MOVE_TIMEOUT] = RST_MOVE_TIMEOUT;
        reg_shadow[REG_BIN_PAUSE]    = RST_BIN_PAUSE;
        seq_mode      = MODE_STOWED;
        servo_deg     = clamp_deg(reg_shadow[REG_ANGLE_STOW]);
        target_deg    = servo_deg;
        since_step    = '0;
        in_move       = '0;
        since_arrival = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 38;
        stall_pct <= 69;
        test_directed_sorts();
        test_config_extremes();
        test_random_traffic(3);

        send_idle_pct = 69;
        stall_pct <= 38;
        test_random_traffic(3);

        send_idle_pct = 0;
        stall_pct <= 0;
        test_random_traffic(3);
        test_backpressure();

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("summary: %0d beats sent, %0d results checked, %0d mismatches",
                 beats_sent, results_checked, mismatches);
        $display("summary: %0d sorts taken, %0d commands refused, %0d bin arrivals, %0d timeouts",
                 sorts_taken, refusals, bin_arrivals, move_timeouts);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/scms_pkg.sv
rtl/scms_cfg.sv
rtl/scms_core.sv
rtl/servo_chute_move_sequencer.sv
rtl/scms_chk.sv
tb/tb_servo_chute_move_sequencer.sv
